[hw/rtl/ascii_chunk_ema_scaler_defines.svh]
// Assertion macros shared by the chunk smoothing block.
`ifndef ASCII_CHUNK_EMA_SCALER_DEFINES_SVH
`define ASCII_CHUNK_EMA_SCALER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ACE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ace_pkg.sv]
// Shared types, constants and helper functions of the chunk smoothing block.
`timescale 1ns / 1ps
`default_nettype none
package ace_pkg;

  localparam int unsigned MAX_CHUNK_DEF = 64;
  localparam int unsigned MAX_FRAC_DEF  = 6;

  localparam int unsigned ACC_W      = 40;
  localparam int unsigned VAL_W      = 48;
  localparam int unsigned ALPHA_W    = 17;
  localparam int unsigned BETA_W     = 24;
  localparam int unsigned CSIZE_W    = 7;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CFG_W      = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned POW_W      = 24;
  localparam int unsigned DIVIDEND_W = ACC_W + 16 + 1;
  localparam int unsigned MUL_A_W    = 32;
  localparam int unsigned MUL_B_W    = 24;
  localparam int unsigned MUL_P_W    = MUL_A_W + MUL_B_W;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE = 2'd2;

  localparam logic [ALPHA_W-1:0]        ALPHA_RST = 17'd0;
  localparam logic signed [BETA_W-1:0]  BETA_RST  = 24'sd65536;
  localparam logic [CSIZE_W-1:0]        CSIZE_RST = 7'd8;
  localparam logic [ALPHA_W-1:0]        ALPHA_ONE = 17'h10000;

  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [DIVIDEND_W-1:0] POS_LIMIT =
    {{(DIVIDEND_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam logic [DIVIDEND_W-1:0] NEG_LIMIT =
    {{(DIVIDEND_W-VAL_W){1'b0}}, 1'b1, {(VAL_W-1){1'b0}}};

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_START,
    PH_INT,
    PH_FRAC,
    PH_STOP
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_DIFF,
    ST_SM_LO,
    ST_SM_HI,
    ST_SM_SUM,
    ST_SM_APPLY,
    ST_SC_PREP,
    ST_SC_LO,
    ST_SC_HI,
    ST_SC_SUM,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic take;
    logic clear;
  } parse_ctrl_t;

  typedef struct packed {
    logic close;
    logic has_chars;
    logic negative;
  } parse_status_t;

  function automatic logic [POW_W-1:0] pow_ten(input logic [2:0] idx);
    logic [POW_W-1:0] p;
    case (idx)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      3'd7:    p = 24'd10000000;
      default: p = 24'd1;
    endcase
    return p;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_value(input logic [DIVIDEND_W-1:0] mag,
                                                        input logic neg);
    logic signed [VAL_W-1:0] r;
    if (neg) begin
      if (mag > NEG_LIMIT) begin
        r = VAL_MIN;
      end else begin
        r = $signed(-mag[VAL_W-1:0]);
      end
    end else begin
      if (mag > POS_LIMIT) begin
        r = VAL_MAX;
      end else begin
        r = $signed(mag[VAL_W-1:0]);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/ace_parser.sv]
// Chunk counter and decimal number parser, one character per request.
`timescale 1ns / 1ps
`default_nettype none
module ace_parser
  import ace_pkg::*;
#(
  parameter int unsigned MAX_CHUNK       = MAX_CHUNK_DEF,
  parameter int unsigned MAX_FRAC_DIGITS = MAX_FRAC_DEF,
  localparam int unsigned FCNT_W = $clog2(MAX_FRAC_DIGITS + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire parse_ctrl_t         ctrl,
  input  wire logic [7:0]          text_byte,
  input  wire logic [CSIZE_W-1:0]  chunk_size,
  output parse_status_t            status,
  output logic [ACC_W-1:0]         acc,
  output logic [FCNT_W-1:0]        fcnt
);

  localparam int unsigned CNT_W = $clog2(MAX_CHUNK + 1);
  localparam int unsigned CMP_W = ((CNT_W > CSIZE_W) ? CNT_W : CSIZE_W) + 1;
  localparam int unsigned X10_W = ACC_W + 4;
  localparam logic [CMP_W-1:0]  CHUNK_LIMIT = CMP_W'(MAX_CHUNK);
  localparam logic [FCNT_W-1:0] FRAC_LIMIT  = FCNT_W'(MAX_FRAC_DIGITS);

  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              has_chars, has_chars_next;
  phase_t            phase, phase_next;
  logic              negative, negative_next;
  logic [ACC_W-1:0]  acc_next;
  logic [FCNT_W-1:0] fcnt_next;
  logic [CMP_W-1:0]  size_eff;
  logic [CMP_W-1:0]  cnt_inc;
  logic              is_char;
  logic              is_digit;
  logic [X10_W-1:0]  acc_x10;
  logic              x10_over;

  always_comb begin
    if (chunk_size == '0) begin
      size_eff = CMP_W'(1);
    end else if (CMP_W'(chunk_size) > CHUNK_LIMIT) begin
      size_eff = CHUNK_LIMIT;
    end else begin
      size_eff = CMP_W'(chunk_size);
    end
  end

  assign cnt_inc  = CMP_W'(cnt) + CMP_W'(1);
  assign is_char  = ctrl.take && (text_byte != CHAR_LF);
  assign is_digit = text_byte inside {[CHAR_ZERO:CHAR_NINE]};
  assign acc_x10  = X10_W'({acc, 3'b000}) + X10_W'({acc, 1'b0}) + X10_W'(text_byte[3:0]);
  assign x10_over = |acc_x10[X10_W-1:ACC_W];

  assign status = '{close:     ctrl.take && (cnt_inc >= size_eff),
                    has_chars: has_chars,
                    negative:  negative};

  always_comb begin
    cnt_next       = cnt;
    has_chars_next = has_chars;
    phase_next     = phase;
    negative_next  = negative;
    acc_next       = acc;
    fcnt_next      = fcnt;
    if (ctrl.clear) begin
      cnt_next       = '0;
      has_chars_next = 1'b0;
      phase_next     = PH_START;
      negative_next  = 1'b0;
      acc_next       = '0;
      fcnt_next      = '0;
    end else if (ctrl.take) begin
      cnt_next = cnt_inc[CNT_W-1:0];
      if (is_char) begin
        has_chars_next = 1'b1;
        case (phase)
          PH_START: begin
            if (text_byte inside {CHAR_SPACE, CHAR_TAB, CHAR_VT, CHAR_FF}) begin
              phase_next = PH_START;
            end else if (text_byte == CHAR_PLUS) begin
              phase_next = PH_INT;
            end else if (text_byte == CHAR_MINUS) begin
              negative_next = 1'b1;
              phase_next    = PH_INT;
            end else if (text_byte == CHAR_POINT) begin
              phase_next = PH_FRAC;
            end else if (is_digit) begin
              acc_next   = ACC_W'(text_byte[3:0]);
              phase_next = PH_INT;
            end else begin
              phase_next = PH_STOP;
            end
          end
          PH_INT: begin
            if (text_byte == CHAR_POINT) begin
              phase_next = PH_FRAC;
            end else if (is_digit) begin
              acc_next = x10_over ? ACC_MAX : acc_x10[ACC_W-1:0];
            end else begin
              phase_next = PH_STOP;
            end
          end
          PH_FRAC: begin
            if (!is_digit) begin
              phase_next = PH_STOP;
            end else if ((fcnt < FRAC_LIMIT) && !x10_over) begin
              acc_next  = acc_x10[ACC_W-1:0];
              fcnt_next = fcnt + FCNT_W'(1);
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      has_chars <= 1'b0;
      phase     <= PH_START;
      negative  <= 1'b0;
      acc       <= '0;
      fcnt      <= '0;
    end else begin
      cnt       <= cnt_next;
      has_chars <= has_chars_next;
      phase     <= phase_next;
      negative  <= negative_next;
      acc       <= acc_next;
      fcnt      <= fcnt_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/ace_divider.sv]
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ace_divider
  import ace_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [POW_W-1:0]      divisor,
  output logic                       busy,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);

  localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

  logic [POW_W-1:0]  rem;
  logic [POW_W-1:0]  dvs;
  logic [STEP_W-1:0] steps;
  logic [POW_W:0]    trial;
  logic              fits;

  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIVIDEND_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? POW_W'(trial - {1'b0, dvs}) : trial[POW_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

[hw/rtl/ascii_chunk_ema_scaler.sv]
// Top level: parses decimal chunks from a byte stream, smooths and scales them.
//
//   Channel  Signals                                       Direction
//   cfg      cfg_write, cfg_index, cfg_data                in
//   in       in_valid/in_ready, text_byte, end_of_file     in
//   out      out_valid/out_ready, smoothed_value,          out
//            scaled_value, sample_number
//
// A request that does not close a chunk is taken without holding the input.
// A request that closes a chunk holds the input while a 57-step restoring
// divider runs, followed by four passes through one shared 32x24 multiplier
// (two passes for the first sample of a sequence).
// Reset is synchronous and clears the control state, configuration and sequence history; no clearing pass is needed.
// A pending result waits in the output register while further bytes are taken;
// the next closing chunk stalls in its final step until that result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "ascii_chunk_ema_scaler_defines.svh"
module ascii_chunk_ema_scaler
  import ace_pkg::*;
#(
  parameter int unsigned MAX_CHUNK       = MAX_CHUNK_DEF,
  parameter int unsigned MAX_FRAC_DIGITS = MAX_FRAC_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            text_byte,
  input  wire logic                  end_of_file,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [VAL_W-1:0]    smoothed_value,
  output logic signed [VAL_W-1:0]    scaled_value,
  output logic [SAMPLE_W-1:0]        sample_number
);

  localparam int unsigned FCNT_W = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int unsigned DIFF_W = VAL_W + 1;
  localparam int unsigned SMS_W  = MUL_P_W + 32 - 22;
  localparam int unsigned APPLY_W = VAL_W + 2;

  seq_state_t state, state_next;

  logic [ALPHA_W-1:0]       alpha;
  logic signed [BETA_W-1:0] beta;
  logic [CSIZE_W-1:0]       chunk_size;
  logic [ALPHA_W-1:0]       alpha_eff;

  parse_ctrl_t       pctrl;
  parse_status_t     pstat;
  logic [ACC_W-1:0]  acc;
  logic [FCNT_W-1:0] fcnt;

  logic                  div_start;
  logic                  div_busy;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quotient;
  logic [POW_W-1:0]      pow;
  logic [DIVIDEND_W-1:0] dividend;

  logic                  in_fire;
  logic                  done_fire;
  logic                  eof_flag;
  logic                  neg;
  logic signed [VAL_W-1:0] x_val;
  logic signed [VAL_W-1:0] y_val;
  logic signed [VAL_W-1:0] prev;
  logic [SAMPLE_W-1:0]   samples_seen;
  logic                  has_history;
  logic [DIFF_W-1:0]     dmag;
  logic                  dneg;
  logic [VAL_W-1:0]      ymag;
  logic [BETA_W-1:0]     bmag;
  logic                  sneg;
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [MUL_P_W-1:0]    prod;
  logic [MUL_P_W-1:0]    part;
  logic [DIVIDEND_W-1:0] sum;

  logic signed [DIFF_W-1:0]  x_ext;
  logic signed [DIFF_W-1:0]  prev_ext;
  logic signed [DIFF_W-1:0]  diff_xp;
  logic signed [DIFF_W-1:0]  diff_px;
  logic [SMS_W-1:0]          sm_full;
  logic [SMS_W-1:0]          sm_round;
  logic signed [APPLY_W-1:0] prev_w;
  logic signed [APPLY_W-1:0] q_w;
  logic signed [APPLY_W-1:0] y_apply;
  logic [DIVIDEND_W-1:0]     sc_sum;

  ace_parser #(
    .MAX_CHUNK       (MAX_CHUNK),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (pctrl),
    .text_byte  (text_byte),
    .chunk_size (chunk_size),
    .status     (pstat),
    .acc        (acc),
    .fcnt       (fcnt)
  );

  assign pow      = pow_ten(3'(fcnt));
  assign dividend = DIVIDEND_W'({acc, 16'h0000}) + DIVIDEND_W'(pow >> 1);

  ace_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (pow),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha      <= ALPHA_RST;
      beta       <= BETA_RST;
      chunk_size <= CSIZE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ALPHA:      alpha      <= cfg_data[ALPHA_W-1:0];
        REG_BETA:       beta       <= $signed(cfg_data[BETA_W-1:0]);
        REG_CHUNK_SIZE: chunk_size <= cfg_data[CSIZE_W-1:0];
        default:        alpha      <= alpha;
      endcase
    end
  end

  assign alpha_eff = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign pctrl    = '{take:  in_fire && !end_of_file && (text_byte != CHAR_CR),
                      clear: (state == ST_START) ||
                             (in_fire && end_of_file && !pstat.has_chars)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    done_fire  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (end_of_file) begin
            if (pstat.has_chars) begin
              state_next = ST_START;
            end
          end else if (pstat.close) begin
            state_next = ST_START;
          end
        end
      end
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        state_next = has_history ? ST_SM_LO : ST_SC_PREP;
      end
      ST_SM_LO: begin
        mul_a      = dmag[MUL_A_W-1:0];
        mul_b      = MUL_B_W'(alpha_eff);
        state_next = ST_SM_HI;
      end
      ST_SM_HI: begin
        mul_a      = MUL_A_W'(dmag[DIFF_W-1:MUL_A_W]);
        mul_b      = MUL_B_W'(alpha_eff);
        state_next = ST_SM_SUM;
      end
      ST_SM_SUM: begin
        state_next = ST_SM_APPLY;
      end
      ST_SM_APPLY: begin
        state_next = ST_SC_PREP;
      end
      ST_SC_PREP: begin
        state_next = ST_SC_LO;
      end
      ST_SC_LO: begin
        mul_a      = ymag[MUL_A_W-1:0];
        mul_b      = bmag;
        state_next = ST_SC_HI;
      end
      ST_SC_HI: begin
        mul_a      = MUL_A_W'(ymag[VAL_W-1:MUL_A_W]);
        mul_b      = bmag;
        state_next = ST_SC_SUM;
      end
      ST_SC_SUM: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          done_fire  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign x_ext    = DIFF_W'(x_val);
  assign prev_ext = DIFF_W'(prev);
  assign diff_xp  = x_ext - prev_ext;
  assign diff_px  = prev_ext - x_ext;

  assign sm_full  = (SMS_W'(prod) << 32) + SMS_W'(part);
  assign sm_round = sm_full + (dneg ? SMS_W'(32767) : SMS_W'(32768));
  assign prev_w   = APPLY_W'(prev);
  assign q_w      = $signed({1'b0, sum[APPLY_W-2:0]});
  assign y_apply  = dneg ? (prev_w - q_w) : (prev_w + q_w);
  assign sc_sum   = (DIVIDEND_W'(prod) << 16) +
                    ((DIVIDEND_W'(part) + DIVIDEND_W'(32768)) >> 16);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_START: begin
        neg <= pstat.negative;
      end
      ST_DIV: begin
        if (div_done) begin
          x_val <= sat_value(div_quotient, neg);
        end
      end
      ST_DIFF: begin
        y_val <= x_val;
        dneg  <= x_val < prev;
        dmag  <= (x_val < prev) ? DIFF_W'(diff_px) : DIFF_W'(diff_xp);
      end
      ST_SM_HI: begin
        part <= prod;
      end
      ST_SM_SUM: begin
        sum <= DIVIDEND_W'(sm_round >> 16);
      end
      ST_SM_APPLY: begin
        y_val <= y_apply[VAL_W-1:0];
      end
      ST_SC_PREP: begin
        ymag <= y_val[VAL_W-1] ? VAL_W'(-y_val) : VAL_W'(y_val);
        bmag <= beta[BETA_W-1] ? BETA_W'(-beta) : BETA_W'(beta);
        sneg <= y_val[VAL_W-1] ^ beta[BETA_W-1];
      end
      ST_SC_HI: begin
        part <= prod;
      end
      ST_SC_SUM: begin
        sum <= sc_sum;
      end
      default: begin
        neg <= neg;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eof_flag     <= 1'b0;
      prev         <= '0;
      samples_seen <= '0;
      has_history  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (in_fire && end_of_file) begin
        if (pstat.has_chars) begin
          eof_flag <= 1'b1;
        end else begin
          prev         <= '0;
          samples_seen <= '0;
          has_history  <= 1'b0;
        end
      end else if (in_fire && pstat.close) begin
        eof_flag <= 1'b0;
      end
      if (done_fire) begin
        if (eof_flag) begin
          prev         <= '0;
          samples_seen <= '0;
          has_history  <= 1'b0;
        end else begin
          prev         <= y_val;
          samples_seen <= samples_seen + SAMPLE_W'(1);
          has_history  <= 1'b1;
        end
      end
      if (done_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      smoothed_value <= y_val;
      scaled_value   <= sat_value(sum, sneg);
      sample_number  <= samples_seen;
    end
  end

  `ACE_ASSERT_SAME(a_div_only_in_div, clk, rst, div_busy, state == ST_DIV, "divider busy outside the divide step")
  `ACE_ASSERT_NEXT(a_close_starts, clk, rst, in_fire && pstat.close, state == ST_START, "closed chunk did not start the computation")
  `ACE_ASSERT_NEXT(a_eof_restarts, clk, rst, done_fire && eof_flag, (samples_seen == '0) && !has_history, "end of file did not restart the sequence")
  `ACE_ASSERT_NEXT(a_sample_count, clk, rst, done_fire && !eof_flag, samples_seen == SAMPLE_W'($past(samples_seen) + SAMPLE_W'(1)), "sample count did not advance by one")

endmodule
`default_nettype wire
